>>> design/substring_search_matcher_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef SUBSTRING_SEARCH_MATCHER_UNIT_ASSERT_SVH
`define SUBSTRING_SEARCH_MATCHER_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define SSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ssm_pkg.sv
package ssm_pkg;

  // Default sizes
  localparam int PATTERN_MAX_DEF = 16;
  localparam int BUFFER_MAX_DEF  = 65536;

  // Field widths fixed by the interface
  localparam int DATA_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int LEN_W   = 5;
  localparam int INDEX_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_BUFFER = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_INDEX    = 2'd2;

  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 5'd1;

  typedef struct packed {
    logic              operation;
    logic [DATA_W-1:0] data_byte;
    logic [SLOT_W-1:0] pattern_slot;
    logic              last_byte;
  } ssm_in_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } ssm_out_t;

  // Item leaving the input register this cycle
  typedef struct packed {
    logic    fire;
    ssm_in_t item;
  } ssm_step_t;

  // Window control from the tracker
  typedef struct packed {
    logic shift;
    logic clear;
  } ssm_ctl_t;

  // ASCII lower-casing when folding is on
  function automatic logic [DATA_W-1:0] fold_byte(input logic [DATA_W-1:0] b,
                                                  input logic en);
    logic [DATA_W-1:0] r;
    r = b;
    if (en && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

>>> design/substring_search_matcher_unit.sv
// Substring search matcher: first occurrence of a pattern in a byte stream.
// Input channel (in_valid / in_stall / in_item): operation 0 loads
// data_byte into pattern_slot; operation 1 streams one buffer byte.
// The item with last_byte set on a buffer byte yields one result on the
// output channel (out_valid / out_stall / out_item): found and the 0-based
// start of the first match at or after start_index (0 when not found).
// Load items and other buffer bytes give no result.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
// pattern_length, case_fold and start_index; cfg_ready is always high.
// Throughput: one item per cycle while the result is not stalled. Each item
// passes through the input register and is compared against the whole window
// in parallel as it leaves; its result is registered before out_valid rises.
// A stalled result holds; one more item can wait in the input register,
// after which in_stall rises. Reset clears the window, the buffer position,
// the match state and both valid flags, and sets pattern_length to 1.
// Pattern slots hold no reset value and must be loaded before use.
module substring_search_matcher_unit #(
  parameter int PATTERN_MAX = ssm_pkg::PATTERN_MAX_DEF,
  parameter int BUFFER_MAX  = ssm_pkg::BUFFER_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ssm_pkg::ssm_in_t               in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ssm_pkg::ssm_out_t              out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssm_pkg::*;

  logic [LEN_W-1:0]   len_r;
  logic               fold_r;
  logic [INDEX_W-1:0] start_r;
  ssm_step_t          step;
  ssm_ctl_t           ctl;
  logic               hit;
  logic               out_free;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= PATTERN_LENGTH_RST;
      fold_r  <= 1'b0;
      start_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: len_r   <= cfg_data[LEN_W-1:0];
        REG_CASE_FOLD:      fold_r  <= cfg_data[0];
        REG_START_INDEX:    start_r <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  ssm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_free (out_free),
    .step     (step)
  );

  ssm_window #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_win (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .ctl            (ctl),
    .pattern_length (len_r),
    .case_fold      (fold_r),
    .hit            (hit)
  );

  ssm_tracker #(
    .PATTERN_MAX (PATTERN_MAX),
    .BUFFER_MAX  (BUFFER_MAX)
  ) u_trk (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .hit            (hit),
    .pattern_length (len_r),
    .start_index    (start_r),
    .ctl            (ctl),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

endmodule

>>> design/ssm_in_stage.sv
module ssm_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ssm_pkg::ssm_in_t   in_item,
  input  logic               out_free,
  output ssm_pkg::ssm_step_t step
);
  import ssm_pkg::*;

  logic    vld_r, vld_nxt;
  ssm_in_t item_r;
  logic    fire;
  logic    take;

  // Item in the register moves on whenever the result slot can take one
  assign fire     = vld_r && out_free;
  assign in_stall = vld_r && !out_free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign step.fire = fire;
  assign step.item = item_r;

endmodule

>>> design/ssm_window.sv
module ssm_window #(
  parameter int PATTERN_MAX = ssm_pkg::PATTERN_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ssm_pkg::ssm_step_t          step,
  input  ssm_pkg::ssm_ctl_t           ctl,
  input  logic [ssm_pkg::LEN_W-1:0]   pattern_length,
  input  logic                        case_fold,
  output logic                        hit
);
  import ssm_pkg::*;

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [DATA_W-1:0] pat_r  [PATTERN_MAX];
  logic [DATA_W-1:0] win_r  [PATTERN_MAX];
  logic [DATA_W-1:0] win_nxt[PATTERN_MAX];
  logic [DATA_W-1:0] newwin [PATTERN_MAX];
  logic [DATA_W-1:0] sel    [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq;
  logic [6:0] slot_ext;
  logic       load_en;

  // Pattern slot write from a load item
  assign slot_ext = {3'b000, step.item.pattern_slot};
  assign load_en  = step.fire && step.item.operation == OP_LOAD &&
                    slot_ext < 7'(PATTERN_MAX);

  always_ff @(posedge clk) begin
    if (load_en) begin
      pat_r[slot_ext[IW-1:0]] <= step.item.data_byte;
    end
  end

  // Window as it stands after this byte is shifted in
  always_comb begin
    newwin[0] = step.item.data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      newwin[k] = win_r[k-1];
    end
  end

  // Slot i lines up with window byte len-1-i
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      sel[i] = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (7'(pattern_length) - 7'd1 - 7'(i) == 7'(k)) begin
          sel[i] = newwin[k];
        end
      end
      eq[i] = (7'(i) >= 7'(pattern_length)) ||
              (fold_byte(pat_r[i], case_fold) == fold_byte(sel[i], case_fold));
    end
  end

  assign hit = &eq;

  // Shift, or clear at the end of a buffer
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (ctl.clear) begin
        win_nxt[k] = '0;
      end else if (ctl.shift) begin
        win_nxt[k] = newwin[k];
      end else begin
        win_nxt[k] = win_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      win_r <= win_nxt;
    end
  end

endmodule

>>> design/ssm_tracker.sv
module ssm_tracker #(
  parameter int PATTERN_MAX = ssm_pkg::PATTERN_MAX_DEF,
  parameter int BUFFER_MAX  = ssm_pkg::BUFFER_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ssm_pkg::ssm_step_t          step,
  input  logic                        hit,
  input  logic [ssm_pkg::LEN_W-1:0]   pattern_length,
  input  logic [ssm_pkg::INDEX_W-1:0] start_index,
  output ssm_pkg::ssm_ctl_t           ctl,
  output logic                        out_free,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ssm_pkg::ssm_out_t           out_item
);
  import ssm_pkg::*;

  localparam int PW = $clog2(BUFFER_MAX + 1);
  localparam int CW = ((PW > INDEX_W) ? PW : INDEX_W) + 2;

  logic [PW-1:0]      pos_r, pos_nxt;
  logic               seen_r, seen_nxt;
  logic [INDEX_W-1:0] first_r, first_nxt;
  logic               oval_r, oval_nxt;
  ssm_out_t           odat_r, odat_nxt;

  logic               is_buf, in_range, shift, report;
  logic               len_ok, end_ok, hit_now, seen_fin;
  logic [CW-1:0]      pos1, need;
  logic [INDEX_W-1:0] start_lo, first_fin;

  assign out_free = !oval_r || !out_stall;

  // Qualify the window compare for this byte
  assign is_buf   = step.fire && step.item.operation == OP_BUFFER;
  assign in_range = pos_r < PW'(BUFFER_MAX);
  assign shift    = is_buf && in_range;
  assign report   = is_buf && step.item.last_byte;
  assign pos1     = CW'(pos_r) + CW'(1);
  assign need     = CW'(pattern_length) + CW'(start_index);
  assign len_ok   = pattern_length != '0 && 7'(pattern_length) <= 7'(PATTERN_MAX);
  assign end_ok   = pos1 >= need;
  assign start_lo = INDEX_W'(pos1 - CW'(pattern_length));
  assign hit_now  = shift && !seen_r && len_ok && end_ok && hit;

  assign seen_fin  = seen_r || hit_now;
  assign first_fin = hit_now ? start_lo : first_r;

  assign ctl.shift = shift;
  assign ctl.clear = report;

  // Buffer state, cleared by the report
  always_comb begin
    pos_nxt   = pos_r;
    seen_nxt  = seen_fin;
    first_nxt = first_fin;
    if (report) begin
      pos_nxt   = '0;
      seen_nxt  = 1'b0;
      first_nxt = '0;
    end else if (shift) begin
      pos_nxt = pos1[PW-1:0];
    end
  end

  // Result register
  always_comb begin
    oval_nxt = oval_r;
    odat_nxt = odat_r;
    if (report) begin
      oval_nxt             = 1'b1;
      odat_nxt.found       = seen_fin;
      odat_nxt.match_index = seen_fin ? first_fin : '0;
    end else if (!out_stall) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      seen_r  <= 1'b0;
      first_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      first_r <= first_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odat_r <= odat_nxt;
  end

  assign out_valid = oval_r;
  assign out_item  = odat_r;

endmodule

>>> design/ssm_checker.sv
`include "substring_search_matcher_unit_assert.svh"

module ssm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input ssm_pkg::ssm_in_t               in_item,
  input logic                           out_valid,
  input logic                           out_stall,
  input ssm_pkg::ssm_out_t              out_item
);
  import ssm_pkg::*;

  // A stalled result holds
  `SSM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "result changed under stall")

  // No index without a match
  `SSM_ASSERT(a_idx_zero, out_valid && !out_item.found |-> out_item.match_index == '0, "match_index set without found")

  // A fresh result comes from a last buffer byte taken earlier
  `SSM_ASSERT(a_rose_src, $rose(out_valid) |-> $past(in_valid && !in_stall && in_item.operation == OP_BUFFER && in_item.last_byte, 2), "result without a last buffer byte")

  // Input backs up only behind a stalled result
  `SSM_ASSERT(a_stall_src, in_stall |-> out_valid && out_stall, "input stalled with output free")

  // Reset empties the result slot
  `SSM_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind substring_search_matcher_unit ssm_checker u_ssm_checker (.*);

>>> verif/substring_search_matcher_unit_tb.sv
module substring_search_matcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssm_pkg::*;

  localparam int NSLOT        = PATTERN_MAX_DEF;
  localparam int BUF_LIMIT    = BUFFER_MAX_DEF;
  localparam int SETTLE       = 4;       // settling wait used by quiesce
  localparam int MAX_CYCLES   = 600000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 1050;
  localparam int MAX_PRINTS   = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  ssm_in_t               in_item;
  logic                  out_valid;
  logic                  out_stall;
  ssm_out_t              out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  substring_search_matcher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Search state mirrored from the block
  logic [7:0]         pat_mem [NSLOT];
  logic [7:0]         win [NSLOT];      // [0] holds the newest byte
  int unsigned        buf_pos;
  bit                 hit;
  int unsigned        hit_pos;
  logic [LEN_W-1:0]   cfg_len;
  bit                 cfg_fold;
  logic [INDEX_W-1:0] cfg_start;
  ssm_out_t           pending_reports [$];

  // Run bookkeeping
  int       err_count;
  int       items_sent;
  int       reports_checked;
  int       reports_found;
  int       cfg_writes;
  int       cycle_count;
  bit       tx_idle;
  bit       rx_idle;
  logic     rx_hold_on;
  int       rx_wait;
  ssm_out_t want_report;

  function automatic logic [7:0] lower_ascii(logic [7:0] b);
    if (cfg_fold && b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  // Newest byte lines up with the last pattern slot in use
  function automatic bit window_equal(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (lower_ascii(pat_mem[i]) != lower_ascii(win[n - 1 - i])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void clear_search();
    for (int i = 0; i < NSLOT; i++) begin
      win[i] = 8'h00;
    end
    buf_pos = 0;
    hit     = 1'b0;
    hit_pos = 0;
  endfunction

  // Advance the search by one accepted item; queue a report on the last byte
  function automatic void search_step(ssm_in_t it);
    ssm_out_t    rep;
    int unsigned len;
    int unsigned pos;
    int unsigned first;
    if (it.operation == OP_LOAD) begin
      pat_mem[it.pattern_slot] = it.data_byte;
      return;
    end
    if (buf_pos < BUF_LIMIT) begin
      len = cfg_len;
      pos = buf_pos;
      for (int i = NSLOT - 1; i > 0; i--) begin
        win[i] = win[i - 1];
      end
      win[0] = it.data_byte;
      buf_pos = pos + 1;
      if (!hit && len != 0 && len <= NSLOT && pos + 1 >= len) begin
        first = pos + 1 - len;
        if (first >= cfg_start && window_equal(len)) begin
          hit     = 1'b1;
          hit_pos = first;
        end
      end
    end
    if (it.last_byte) begin
      rep.found       = hit;
      rep.match_index = hit ? hit_pos[INDEX_W-1:0] : '0;
      pending_reports.push_back(rep);
      clear_search();
    end
  endfunction

  // Track register writes and accepted items
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: cfg_len = cfg_data[LEN_W-1:0];
          REG_CASE_FOLD:      cfg_fold = cfg_data[0];
          REG_START_INDEX:    cfg_start = cfg_data[INDEX_W-1:0];
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        search_step(in_item);
      end
    end
  end

  // Compare each accepted report with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        err_count++;
        if (err_count <= MAX_PRINTS) begin
          $display("%0t: unexpected report found=%0d index=%0d", $time,
                   out_item.found, out_item.match_index);
        end
      end else begin
        want_report = pending_reports.pop_front();
        reports_checked++;
        if (want_report.found) begin
          reports_found++;
        end
        if (out_item.found !== want_report.found ||
            out_item.match_index !== want_report.match_index) begin
          err_count++;
          if (err_count <= MAX_PRINTS) begin
            $display("%0t: report mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
                     $time, want_report.found, want_report.match_index,
                     out_item.found, out_item.match_index);
          end
        end
      end
    end
  end

  // Receiver: random wait per report, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
      end
      if (rx_hold_on) begin
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d reports outstanding", $time,
               cycle_count, pending_reports.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // One item; valid stays high across back-to-back items
  task automatic send_item(logic op, logic [7:0] b, logic [SLOT_W-1:0] slot, logic last);
    int      gap;
    ssm_in_t it;
    gap             = tx_idle ? $urandom_range(0, 6) : 0;
    it.operation    = op;
    it.data_byte    = b;
    it.pattern_slot = slot;
    it.last_byte    = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_slot(int slot, logic [7:0] b);
    send_item(OP_LOAD, b, SLOT_W'(slot), 1'b0);
  endtask

  task automatic push_byte(logic [7:0] b, logic last);
    send_item(OP_BUFFER, b, SLOT_W'($urandom_range(0, NSLOT - 1)), last);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Stop sending and wait for every report plus the pipe latency
  task automatic quiesce();
    in_valid <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(int len, int fold, int start);
    write_reg(REG_PATTERN_LENGTH, len);
    write_reg(REG_CASE_FOLD, fold);
    write_reg(REG_START_INDEX, start);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h61;
      2, 3:    return 8'h41;
      4, 5:    return 8'h62;
      6, 7:    return 8'h42;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Fill every slot under the reset settings, then search with length one
  task automatic test_reset_defaults();
    for (int i = 0; i < NSLOT - 2; i++) begin
      load_slot(i, 8'h41 + 8'(i));
    end
    load_slot(NSLOT - 2, 8'h00);
    load_slot(NSLOT - 1, 8'hFF);
    send_item(OP_LOAD, 8'h41, '0, 1'b1);   // last flag on a load is ignored
    push_text("aAA");
  endtask

  task automatic test_length_extremes();
    quiesce();
    set_config(NSLOT, 0, 0);
    push_byte(8'h58, 1'b0);
    for (int i = 0; i < NSLOT; i++) begin
      push_byte(pat_mem[i], i == NSLOT - 1);
    end
    quiesce();
    set_config(0, 0, 0);
    push_text("AA");
    quiesce();
    set_config(NSLOT + 1, 0, 0);
    push_text("AB");
    quiesce();
    set_config(31, 0, 0);
    push_text("A");
    // buffer shorter than the pattern
    quiesce();
    set_config(3, 0, 0);
    push_text("AB");
    quiesce();
    set_config(1, 0, 0);
    push_text("B");
    push_text("A");
  endtask

  task automatic test_case_fold();
    quiesce();
    set_config(2, 1, 0);
    load_slot(0, "q");
    load_slot(1, "Z");
    push_text("xQz");
    quiesce();
    set_config(2, 0, 0);
    push_text("QzqZ");
    // bytes just outside A..Z must not fold
    load_slot(0, "@");
    load_slot(1, "[");
    quiesce();
    set_config(2, 1, 0);
    push_text("`{@[");
  endtask

  task automatic test_start_index();
    load_slot(0, "A");
    load_slot(1, "B");
    quiesce();
    set_config(1, 0, 3);
    push_text("AAAAAA");
    quiesce();
    set_config(1, 0, 16'hFFFF);
    push_text("AAA");
    // settings changed inside a buffer apply to later bytes only
    quiesce();
    set_config(1, 0, 1);
    push_byte("A", 1'b0);
    quiesce();
    set_config(1, 0, 0);
    push_byte("B", 1'b0);
    quiesce();
    set_config(2, 0, 0);
    push_text("CAB");
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    quiesce();
    set_config(1, 0, 0);
    tx_idle = 1'b0;
    fork
      begin
        rx_hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_on <= 1'b0;
      end
      for (int n = 0; n < 15; n++) begin
        push_byte($urandom_range(0, 1) ? "A" : "B", 1'b0);
        push_byte($urandom_range(0, 1) ? "A" : "B", 1'b0);
        push_byte($urandom_range(0, 1) ? "A" : "B", 1'b1);
      end
    join
    quiesce();
    tx_idle = 1'b1;
  endtask

  // Random buffers, about half with the current pattern planted inside
  task automatic test_random();
    int         base;
    int         blen;
    int         plen;
    int         plant_at;
    int         len;
    int         start;
    logic [7:0] b;
    base = items_sent;
    while (items_sent < base + RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(0, 4) != 0);
      rx_idle = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 19))
          0:       len = 0;
          1:       len = NSLOT;
          2:       len = $urandom_range(NSLOT + 1, 31);
          default: len = $urandom_range(1, 5);
        endcase
        case ($urandom_range(0, 9))
          0:       start = $urandom_range(0, 16'hFFFF);
          1:       start = 16'hFFFF;
          default: start = $urandom_range(0, 8);
        endcase
        quiesce();
        set_config(len, $urandom_range(0, 1), start);
      end
      repeat ($urandom_range(0, 3)) begin
        send_item(OP_LOAD, pick_char(), SLOT_W'($urandom_range(0, NSLOT - 1)),
                  1'($urandom_range(0, 1)));
      end
      blen     = $urandom_range(1, 24);
      plen     = (cfg_len >= 1 && cfg_len <= NSLOT) ? int'(cfg_len) : 0;
      plant_at = (plen > 0 && $urandom_range(0, 1)) ? $urandom_range(0, blen - 1) : -1;
      for (int k = 0; k < blen; k++) begin
        // stray pattern loads inside the buffer
        if ($urandom_range(0, 19) == 0) begin
          send_item(OP_LOAD, pick_char(), SLOT_W'($urandom_range(0, NSLOT - 1)),
                    1'($urandom_range(0, 1)));
        end
        if (plant_at >= 0 && k >= plant_at && k < plant_at + plen) begin
          b = pat_mem[k - plant_at];
          if ($urandom_range(0, 1) &&
              ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))) begin
            b = b ^ 8'h20;
          end
        end else begin
          b = pick_char();
        end
        push_byte(b, k == blen - 1);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rx_hold_on = 1'b0;
    rx_wait    = 0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    for (int i = 0; i < NSLOT; i++) begin
      pat_mem[i] = 8'h00;
    end
    clear_search();
    cfg_len   = PATTERN_LENGTH_RST;
    cfg_fold  = 1'b0;
    cfg_start = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_length_extremes();
    test_case_fold();
    test_start_index();
    test_backpressure();
    test_random();
    quiesce();

    $display("Ran %0d items and %0d register writes; checked %0d reports, %0d with a match.",
             items_sent, cfg_writes, reports_checked, reports_found);
    $display("Covered lengths 0 to 31, case folding, start index limits, long output stalls.");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
